FILE: hw/rtl/ehsd_pkg.sv
// Shared types, codes and character helpers for the escape-hex stream decoder.
// No dependencies; imported by escape_hex_stream_decoder_core.
`default_nettype none

package ehsd_pkg;

  localparam logic [7:0]  ESC_MARK       = 8'h5F;
  localparam logic [7:0]  CHAR_NUL       = 8'h00;
  localparam logic [11:0] UNIT_LIMIT_RST = 12'd1023;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_WIDE_MODE  = 2'd0,
    CFG_UNIT_LIMIT = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_ESC = 3'd1,
    ST_ODD     = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_CUT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        end_flag;
    logic [2:0]  status;
    logic [11:0] count;
  } res_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) begin
      r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h61 + 8'd10;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h41 + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/escape_hex_stream_decoder_core.sv
// Escape-hex stream decoder core: escape state machine and result queue.
// Depends on ehsd_pkg.
//
// Usage:
//   in channel  : one ASCII character per beat (in_char); NUL ends a string.
//   out channel : one result per beat; a unit result carries a decoded byte
//                 or UTF-16 code unit, the end result (out_end = 1) carries
//                 the string status and unit count and is last of the string.
//   cfg channel : cfg_index 0 = wide_mode, 1 = unit_limit; always ready.
//                 Other indexes are ignored. Write only while idle.
// A result is written into the result queue as its character is taken.
// Throughput: one character per cycle while in_ready is high; the decode
// is a single pass of logic from the input port into a 4-entry result queue.
// A character can cause two results (NUL ending a byte-mode escape after
// one digit), so in_ready requires two free queue entries.
// Stall: while out_ready is low the queue fills and in_ready drops once
// fewer than two entries are free; nothing is lost.
// Reset: queue emptied, string state cleared, wide_mode = 0,
// unit_limit = 1023.
`default_nettype none

module escape_hex_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_unit,
  output logic             out_end,
  output logic [2:0]       out_status,
  output logic [11:0]      out_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import ehsd_pkg::*;

  // configuration
  logic        wide_mode;
  logic [11:0] unit_limit;

  // per-string state
  phase_t      escape_phase, escape_phase_next;
  logic [3:0]  first_nibble, first_nibble_next;
  logic [7:0]  low_byte, low_byte_next;
  logic        have_low, have_low_next;
  logic [11:0] unit_count, unit_count_next;
  status_t     stop_status, stop_status_next;

  // result queue
  res_t                q_mem [OUT_DEPTH];
  logic [OUT_AW-1:0]   wr_ptr, rd_ptr;
  logic [OUT_CW-1:0]   q_count, q_count_next;

  logic       in_fire, out_fire;
  logic [1:0] n_res;
  res_t       r0, r1;

  assign cfg_ready = 1'b1;
  assign in_ready  = (q_count <= OUT_CW'(OUT_DEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (q_count != '0);
  assign out_fire  = out_valid && out_ready;

  assign out_unit   = q_mem[rd_ptr].unit;
  assign out_end    = q_mem[rd_ptr].end_flag;
  assign out_status = q_mem[rd_ptr].status;
  assign out_count  = q_mem[rd_ptr].count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode  <= 1'b0;
      unit_limit <= UNIT_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDE_MODE:  wide_mode  <= cfg_data[0];
        CFG_UNIT_LIMIT: unit_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode one character
  always_comb begin
    logic [7:0]  byte_val;
    logic        go;
    logic [11:0] cnt;
    status_t     st;

    escape_phase_next = escape_phase;
    first_nibble_next = first_nibble;
    low_byte_next     = low_byte;
    have_low_next     = have_low;
    unit_count_next   = unit_count;
    stop_status_next  = stop_status;
    n_res             = 2'd0;
    r0                = '0;
    r1                = '0;
    byte_val          = in_char;
    go                = 1'b0;
    cnt               = unit_count + 12'd1;
    st                = stop_status;

    if (in_char == CHAR_NUL) begin
      if (stop_status == ST_OK) begin
        if (wide_mode) begin
          if (escape_phase != PH_NONE) st = ST_BAD_ESC;
          else if (have_low)           st = ST_ODD;
        end else if (escape_phase == PH_FIRST) begin
          st = ST_CUT;
        end else if (escape_phase == PH_SECOND) begin
          // lenient: the single digit becomes a unit
          r0    = '{unit: {12'h000, first_nibble}, end_flag: 1'b0,
                    status: ST_OK, count: cnt};
          n_res = 2'd1;
          st    = ST_CUT;
        end
      end
      if (n_res == 2'd1) begin
        r1    = '{unit: 16'h0000, end_flag: 1'b1, status: st, count: cnt};
        n_res = 2'd2;
      end else begin
        r0    = '{unit: 16'h0000, end_flag: 1'b1, status: st,
                  count: unit_count};
        n_res = 2'd1;
      end
      escape_phase_next = PH_NONE;
      first_nibble_next = 4'h0;
      low_byte_next     = 8'h00;
      have_low_next     = 1'b0;
      unit_count_next   = 12'h000;
      stop_status_next  = ST_OK;
    end else if (stop_status != ST_OK) begin
      // ignore until NUL
    end else if (escape_phase == PH_NONE && (!wide_mode || !have_low) &&
                 unit_count >= unit_limit) begin
      stop_status_next = ST_LIMIT;
    end else begin
      if (escape_phase == PH_NONE) begin
        if (in_char == ESC_MARK) begin
          escape_phase_next = PH_FIRST;
        end else begin
          go = 1'b1;
        end
      end else if (wide_mode && !is_hex(in_char)) begin
        stop_status_next  = ST_BAD_ESC;
        escape_phase_next = PH_NONE;
      end else if (escape_phase == PH_FIRST) begin
        first_nibble_next = hex_val(in_char);
        escape_phase_next = PH_SECOND;
      end else begin
        byte_val          = {first_nibble, hex_val(in_char)};
        escape_phase_next = PH_NONE;
        go                = 1'b1;
      end

      if (go) begin
        if (!wide_mode) begin
          unit_count_next = cnt;
          r0    = '{unit: {8'h00, byte_val}, end_flag: 1'b0, status: ST_OK,
                    count: cnt};
          n_res = 2'd1;
        end else if (!have_low) begin
          low_byte_next = byte_val;
          have_low_next = 1'b1;
        end else begin
          have_low_next   = 1'b0;
          unit_count_next = cnt;
          r0    = '{unit: {byte_val, low_byte}, end_flag: 1'b0, status: ST_OK,
                    count: cnt};
          n_res = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= PH_NONE;
      first_nibble <= 4'h0;
      low_byte     <= 8'h00;
      have_low     <= 1'b0;
      unit_count   <= 12'h000;
      stop_status  <= ST_OK;
    end else if (in_fire) begin
      escape_phase <= escape_phase_next;
      first_nibble <= first_nibble_next;
      low_byte     <= low_byte_next;
      have_low     <= have_low_next;
      unit_count   <= unit_count_next;
      stop_status  <= stop_status_next;
    end
  end

  // queue storage: payload only, no reset
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      q_mem[wr_ptr] <= r0;
      if (n_res == 2'd2) begin
        q_mem[wr_ptr + OUT_AW'(1)] <= r1;
      end
    end
  end

  always_comb begin
    q_count_next = q_count;
    if (in_fire) q_count_next = q_count_next + OUT_CW'(n_res);
    if (out_fire) q_count_next = q_count_next - OUT_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (in_fire) wr_ptr <= wr_ptr + OUT_AW'(n_res);
      if (out_fire) rd_ptr <= rd_ptr + OUT_AW'(1);
      q_count <= q_count_next;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= OUT_CW'(OUT_DEPTH))
    else $error("result queue overflow");

  a_stop_no_escape: assert property (@(posedge clk) disable iff (rst)
    stop_status != ST_OK |-> escape_phase == PH_NONE)
    else $error("escape pending after decode stopped");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_char == CHAR_NUL |=>
      unit_count == 12'h000 && stop_status == ST_OK && !have_low)
    else $error("string state not cleared after NUL");

  a_end_unit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |-> out_unit == 16'h0000)
    else $error("end result carries nonzero unit");

endmodule

`default_nettype wire
